@@ rtl/mre_pkg.sv @@
// Shared types and constants for the MPU region encoder.
// Standalone package; every rtl module imports it.
package mre_pkg;

  localparam logic [1:0] KIND_DEVICE = 2'd0;
  localparam logic [1:0] KIND_MEMORY = 2'd1;

  localparam logic [1:0] ATTR_DEVICE  = 2'd0;
  localparam logic [1:0] ATTR_WB_WA   = 2'd1;
  localparam logic [1:0] ATTR_WT      = 2'd2;
  localparam logic [1:0] ATTR_NOCACHE = 2'd3;

  // Smallest legal region is 32 bytes; a subregion is an eighth of a region.
  localparam logic [5:0] MIN_LOG   = 6'd5;
  localparam logic [5:0] MAX_LOG   = 6'd32;
  localparam logic [5:0] SUB_SHIFT = 6'd3;

  typedef struct packed {
    logic        area_used;
    logic [31:0] base_addr;
    logic [31:0] byte_len;
    logic        writable;
    logic [1:0]  region_kind;
    logic        cacheable;
    logic        executable;
  } area_t;

  typedef struct packed {
    logic        error;
    logic        region_enable;
    logic [31:0] region_address;
    logic [4:0]  size_code;
    logic [7:0]  subregion_mask;
    logic        access_rw;
    logic [1:0]  memory_attr;
    logic        execute_never;
  } region_t;

  typedef struct packed {
    logic       used;
    logic       writable;
    logic [1:0] kind;
    logic       cacheable;
    logic       executable;
  } attr_t;

  typedef struct packed {
    logic        valid;
    attr_t       attr;
    logic [31:0] base;
    logic [31:0] size;
    logic [32:0] end_addr;
    logic [5:0]  log_size;
  } size_stage_t;

  typedef struct packed {
    logic        valid;
    attr_t       attr;
    logic        error;
    logic [31:0] rbase;
    logic [5:0]  log_size;
    logic [31:0] lo_off;
    logic [33:0] hi_off;
  } align_stage_t;

  // Number of significant bits in v (index of highest set bit plus one).
  function automatic logic [5:0] msb_count(logic [31:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/mre_sizer.sv @@
// Region sizing: ceil(log2(size)) and area end, then one optional doubling.
// Two register stages. Depends on mre_pkg.
module mre_sizer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  mre_pkg::area_t            area,
  output mre_pkg::size_stage_t      sized
);
  import mre_pkg::*;

  size_stage_t s1;
  logic [31:0] size_m1;
  logic [5:0]  log_first;
  logic [32:0] end_first;
  logic [33:0] rsize;
  logic [33:0] rtop;
  logic        grow;

  always_comb begin
    size_m1   = area.byte_len - 32'd1;
    log_first = (area.byte_len == 32'd0) ? 6'd0 : msb_count(size_m1);
    end_first = {1'b0, area.base_addr} + {1'b0, area.byte_len};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= in_valid;
    end
    s1.attr.used       <= area.area_used;
    s1.attr.writable   <= area.area_used & area.writable;
    s1.attr.kind       <= area.region_kind;
    s1.attr.cacheable  <= area.cacheable;
    s1.attr.executable <= area.executable;
    s1.base            <= area.base_addr;
    s1.size            <= area.byte_len;
    s1.end_addr        <= end_first;
    s1.log_size        <= log_first;
  end

  // Double the region once if the area runs past the aligned region top.
  always_comb begin
    rsize = 34'd1 << s1.log_size;
    rtop  = ({2'b00, s1.base} & ~(rsize - 34'd1)) + rsize;
    grow  = {1'b0, s1.end_addr} > rtop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sized.valid <= 1'b0;
    end else begin
      sized.valid <= s1.valid;
    end
    sized.attr     <= s1.attr;
    sized.base     <= s1.base;
    sized.size     <= s1.size;
    sized.end_addr <= s1.end_addr;
    sized.log_size <= s1.log_size + {5'd0, grow};
  end

endmodule

@@ rtl/mre_aligner.sv @@
// Region base alignment, error checks and subregion offsets.
// One register stage. Depends on mre_pkg.
module mre_aligner (
  input  logic                      clk,
  input  logic                      rst,
  input  mre_pkg::size_stage_t      sized,
  output mre_pkg::align_stage_t     aligned
);
  import mre_pkg::*;

  logic [33:0] rsize;
  logic [33:0] rmask;
  logic [33:0] rbase;
  logic [33:0] submask;
  logic        bad_align;
  logic        end_over;
  logic        bad_log;
  logic        bad_kind;

  always_comb begin
    rsize     = 34'd1 << sized.log_size;
    rmask     = rsize - 34'd1;
    rbase     = {2'b00, sized.base} & ~rmask;
    submask   = rmask >> SUB_SHIFT;
    bad_align = |(({2'b00, sized.base} | {2'b00, sized.size}) & submask);
    end_over  = sized.end_addr[32] && (sized.end_addr[31:0] != 32'd0);
    bad_log   = (sized.log_size > MAX_LOG) || (sized.log_size < MIN_LOG);
    bad_kind  = (sized.attr.kind != KIND_DEVICE) && (sized.attr.kind != KIND_MEMORY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aligned.valid <= 1'b0;
    end else begin
      aligned.valid <= sized.valid;
    end
    aligned.attr     <= sized.attr;
    aligned.error    <= bad_align | end_over | bad_log | bad_kind;
    aligned.rbase    <= rbase[31:0];
    aligned.log_size <= sized.log_size;
    aligned.lo_off   <= sized.base & rmask[31:0];
    aligned.hi_off   <= rbase + rsize - {1'b0, sized.end_addr};
  end

endmodule

@@ rtl/mre_subregion.sv @@
// Subregion disable mask, size code and attribute coding; output register.
// Depends on mre_pkg.
module mre_subregion (
  input  logic                      clk,
  input  logic                      rst,
  input  mre_pkg::align_stage_t     aligned,
  output logic                      done,
  output mre_pkg::region_t          result
);
  import mre_pkg::*;

  logic [4:0] sh;
  logic [2:0] lo;
  logic [3:0] hi;
  logic [7:0] low_bits;
  logic [7:0] high_bits;
  region_t    region_next;

  always_comb begin
    sh        = 5'(aligned.log_size - SUB_SHIFT);
    lo        = 3'(aligned.lo_off >> sh);
    // an area that still spills past the doubled region disables every upper eighth
    hi        = aligned.hi_off[33] ? 4'd8 : 4'(aligned.hi_off >> sh);
    low_bits  = 8'((9'd1 << lo) - 9'd1);
    high_bits = 8'(16'hFF00 >> hi);

    region_next = '0;
    if (aligned.attr.used) begin
      if (aligned.error) begin
        region_next.error = 1'b1;
      end else begin
        region_next.region_enable  = 1'b1;
        region_next.region_address = aligned.rbase;
        region_next.size_code      = 5'(aligned.log_size - 6'd1);
        region_next.subregion_mask = low_bits | high_bits;
        region_next.access_rw      = aligned.attr.writable;
        if (aligned.attr.kind == KIND_DEVICE) begin
          region_next.memory_attr   = ATTR_DEVICE;
          region_next.execute_never = 1'b0;
        end else begin
          if (aligned.attr.cacheable) begin
            region_next.memory_attr = aligned.attr.writable ? ATTR_WB_WA : ATTR_WT;
          end else begin
            region_next.memory_attr = ATTR_NOCACHE;
          end
          region_next.execute_never = ~aligned.attr.executable;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= aligned.valid;
    end
    result <= region_next;
  end

endmodule

@@ rtl/mpu_region_encoder.sv @@
// Top level of the MPU region encoder: sizer, aligner, subregion stages.
// Depends on mre_pkg, mre_sizer, mre_aligner, mre_subregion.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------
//   request  | start, busy (output) | area   (area_t)
//   result   | done strobe          | result (region_t)
//
// One transaction per cycle; results pass the sizer, aligner and output
// registers in turn: log2 search, region doubling, alignment and error
// checks, then mask build in the output register.
// busy is high only while rst is asserted; reset clears all valid bits.
// The receiver cannot stall, so the pipeline always advances.
module mpu_region_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mre_pkg::area_t    area,
  output logic              done,
  output mre_pkg::region_t  result
);
  import mre_pkg::*;

  size_stage_t  sized;
  align_stage_t aligned;
  logic         accept;

  assign busy   = rst;
  assign accept = start & ~busy;

  mre_sizer u_sizer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .area     (area),
    .sized    (sized)
  );

  mre_aligner u_aligner (
    .clk     (clk),
    .rst     (rst),
    .sized   (sized),
    .aligned (aligned)
  );

  mre_subregion u_subregion (
    .clk     (clk),
    .rst     (rst),
    .aligned (aligned),
    .done    (done),
    .result  (result)
  );

`ifndef SYNTH
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done)
    else $error("accepted transaction did not complete in four cycles");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching transaction");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.error |-> !result.region_enable && result.region_address == 32'd0)
    else $error("error result carries region fields");
`endif

endmodule
